@@ rtl/gas_flame_alarm_qualifier_macros.svh @@
// Assertion helpers, included by gas_flame_alarm_qualifier.sv.
// Both sample on clk and are disabled while rst is high.
`ifndef GAS_FLAME_ALARM_QUALIFIER_MACROS_SVH
`define GAS_FLAME_ALARM_QUALIFIER_MACROS_SVH

// Same-cycle implication
`define GFAQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define GFAQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/gfaq_pkg.sv @@
package gfaq_pkg;

  // Configuration register map
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_TRIP_LEVEL      = 3'd0,
    CFG_REARM_THRESHOLD = 3'd1,
    CFG_DROP_MARGIN     = 3'd2,
    CFG_LOCK_DECLINES   = 3'd3,
    CFG_CLEAR_HOLD      = 3'd4,
    CFG_FLAME_HOLD      = 3'd5
  } cfg_reg_t;

  // Register reset values
  localparam int TRIP_LEVEL_RST      = 450;
  localparam int REARM_THRESHOLD_RST = 400;
  localparam int DROP_MARGIN_RST     = 50;
  localparam int LOCK_DECLINES_RST   = 2;
  localparam int CLEAR_HOLD_RST      = 2000;
  localparam int FLAME_HOLD_RST      = 500;

  // Hold times and decline counter have fixed widths
  localparam int HOLD_BITS    = 16;
  localparam int DECLINE_BITS = 10;
  localparam logic [DECLINE_BITS-1:0] DECLINE_MAX = 10'd1000;

endpackage

@@ rtl/gfaq_flame_qual.sv @@
// Flame qualifier: raw flame must persist for hold_ms before it counts.
module gfaq_flame_qual
  import gfaq_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 flame,
  input  logic [TIME_BITS-1:0] now,
  input  logic [HOLD_BITS-1:0] hold_ms,
  output logic                 confirmed_next
);

  logic                 pending;
  logic                 confirmed;
  logic [TIME_BITS-1:0] start_ms;
  logic [TIME_BITS-1:0] elapsed;

  assign elapsed = now - start_ms;

  // confirmed only ever set while pending, so it holds on the first flame item
  always_comb begin
    if (!flame) begin
      confirmed_next = 1'b0;
    end else if (pending && elapsed >= TIME_BITS'(hold_ms)) begin
      confirmed_next = 1'b1;
    end else begin
      confirmed_next = confirmed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 1'b0;
      confirmed <= 1'b0;
    end else if (step) begin
      pending   <= flame;
      confirmed <= confirmed_next;
    end
  end

  // start time captured on the first flame item
  always_ff @(posedge clk) begin
    if (step && flame && !pending) begin
      start_ms <= now;
    end
  end

endmodule

@@ rtl/gas_flame_alarm_qualifier.sv @@
// Gas and flame alarm qualifier, one sensor channel.
// Input channel: in_valid / in_stall carry now_ms, gas_level and flame_seen.
// Output channel: out_valid / out_stall carry one result per request: alarm,
// alarm_raised, alarm_cleared, rearm_pending, flame_confirmed_out, peak_level.
// A request is taken when valid is high and stall is low.
// Configuration: cfg_write with cfg_index and cfg_data writes one register
// (0 gas threshold, 1 rearm threshold, 2 peak drop, 3 decline confirm,
// 4 clear hold ms, 5 flame hold ms); other indexes are ignored.
// Path: an accepted request is held in the input register, then its result is
// captured in the result register, where out_valid rises. One request per cycle
// while out_stall does not hold a result; the whole state update is one pass of
// compare and add logic between the two registers.
// Reset (rst, synchronous): both pipeline stages empty, alarm idle, tracker
// zeroed, registers back to their default values.
// When out_stall holds a result, the input register holds its request and
// in_stall rises only if that register is occupied; no request is dropped.
`include "gas_flame_alarm_qualifier_macros.svh"
module gas_flame_alarm_qualifier
  import gfaq_pkg::*;
#(
  parameter int SAMPLE_BITS = 10,
  parameter int TIME_BITS   = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [TIME_BITS-1:0]     now_ms,
  input  logic [SAMPLE_BITS-1:0]   gas_level,
  input  logic                     flame_seen,
  // output channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     alarm,
  output logic                     alarm_raised,
  output logic                     alarm_cleared,
  output logic                     rearm_pending,
  output logic                     flame_confirmed_out,
  output logic [SAMPLE_BITS-1:0]   peak_level
);

  // Configuration registers
  logic [SAMPLE_BITS-1:0]  trip_level;
  logic [SAMPLE_BITS-1:0]  rearm_threshold;
  logic [SAMPLE_BITS-1:0]  drop_margin;
  logic [DECLINE_BITS-1:0] lock_declines;
  logic [HOLD_BITS-1:0]    clear_hold;
  logic [HOLD_BITS-1:0]    flame_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      trip_level      <= SAMPLE_BITS'(TRIP_LEVEL_RST);
      rearm_threshold <= SAMPLE_BITS'(REARM_THRESHOLD_RST);
      drop_margin     <= SAMPLE_BITS'(DROP_MARGIN_RST);
      lock_declines   <= DECLINE_BITS'(LOCK_DECLINES_RST);
      clear_hold      <= HOLD_BITS'(CLEAR_HOLD_RST);
      flame_hold      <= HOLD_BITS'(FLAME_HOLD_RST);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_TRIP_LEVEL:      trip_level      <= cfg_data[SAMPLE_BITS-1:0];
        CFG_REARM_THRESHOLD: rearm_threshold <= cfg_data[SAMPLE_BITS-1:0];
        CFG_DROP_MARGIN:     drop_margin     <= cfg_data[SAMPLE_BITS-1:0];
        CFG_LOCK_DECLINES:   lock_declines   <= cfg_data[DECLINE_BITS-1:0];
        CFG_CLEAR_HOLD:      clear_hold      <= cfg_data[HOLD_BITS-1:0];
        CFG_FLAME_HOLD:      flame_hold      <= cfg_data[HOLD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: stage 1 is the input register, stage 2 the result
  logic advance;
  logic step;
  logic s1_valid;
  logic [TIME_BITS-1:0]   s1_now;
  logic [SAMPLE_BITS-1:0] s1_gas;
  logic                   s1_flame;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign step     = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_now   <= now_ms;
      s1_gas   <= gas_level;
      s1_flame <= flame_seen;
    end
  end

  // Flame qualification
  logic flame_conf_next;

  gfaq_flame_qual #(
    .TIME_BITS (TIME_BITS)
  ) u_flame (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .flame          (s1_flame),
    .now            (s1_now),
    .hold_ms        (flame_hold),
    .confirmed_next (flame_conf_next)
  );

  // Alarm and peak tracker state
  logic                    alarm_active;
  logic                    need_rearm;
  logic [SAMPLE_BITS-1:0]  peak_value;
  logic [SAMPLE_BITS-1:0]  previous_sample;
  logic [DECLINE_BITS-1:0] decline_count;
  logic                    peak_locked;
  logic                    clear_pending;
  logic [TIME_BITS-1:0]    clear_start_ms;

  logic                    alarm_active_next;
  logic                    need_rearm_next;
  logic [SAMPLE_BITS-1:0]  peak_value_next;
  logic [SAMPLE_BITS-1:0]  previous_sample_next;
  logic [DECLINE_BITS-1:0] decline_count_next;
  logic                    peak_locked_next;
  logic                    clear_pending_next;
  logic                    clear_start_load;
  logic                    raised;
  logic                    cleared;

  logic                    rearm_kept;
  logic [DECLINE_BITS-1:0] decline_inc;
  logic [SAMPLE_BITS:0]    gas_plus_drop;
  logic [TIME_BITS-1:0]    clear_elapsed;
  logic                    clear_cond;

  assign rearm_kept    = need_rearm && !(s1_gas < rearm_threshold);
  assign decline_inc   = (decline_count < DECLINE_MAX) ? decline_count + 1'b1
                                                       : decline_count;
  assign gas_plus_drop = {1'b0, s1_gas} + {1'b0, drop_margin};
  assign clear_elapsed = s1_now - clear_start_ms;

  // One item's state update
  always_comb begin
    alarm_active_next    = alarm_active;
    need_rearm_next      = rearm_kept;
    peak_value_next      = peak_value;
    previous_sample_next = previous_sample;
    decline_count_next   = decline_count;
    peak_locked_next     = peak_locked;
    clear_pending_next   = clear_pending;
    clear_start_load     = 1'b0;
    raised               = 1'b0;
    cleared              = 1'b0;
    clear_cond           = 1'b0;

    if (!alarm_active) begin
      // trigger: seed the tracker with this sample
      if (!rearm_kept && (s1_gas > trip_level || flame_conf_next)) begin
        alarm_active_next    = 1'b1;
        raised               = 1'b1;
        peak_value_next      = s1_gas;
        previous_sample_next = s1_gas;
        decline_count_next   = '0;
        peak_locked_next     = 1'b0;
        clear_pending_next   = 1'b0;
      end
    end else begin
      // peak tracking
      if (s1_gas > peak_value) begin
        peak_value_next    = s1_gas;
        decline_count_next = '0;
        peak_locked_next   = 1'b0;
        clear_pending_next = 1'b0;
      end else if (s1_gas < previous_sample) begin
        decline_count_next = decline_inc;
        if (decline_inc >= lock_declines) begin
          peak_locked_next = 1'b1;
        end
      end else if (!peak_locked) begin
        decline_count_next = '0;
      end
      previous_sample_next = s1_gas;

      // clear qualification
      clear_cond = !s1_flame &&
                   ((peak_locked_next && gas_plus_drop <= {1'b0, peak_value_next}) ||
                    s1_gas < trip_level);
      if (clear_cond) begin
        if (!clear_pending_next) begin
          clear_pending_next = 1'b1;
          clear_start_load   = 1'b1;
        end else if (clear_elapsed >= TIME_BITS'(clear_hold)) begin
          cleared = 1'b1;
        end
      end else begin
        clear_pending_next = 1'b0;
      end

      if (cleared) begin
        need_rearm_next      = rearm_kept || !(s1_gas < trip_level);
        alarm_active_next    = 1'b0;
        peak_value_next      = '0;
        previous_sample_next = '0;
        decline_count_next   = '0;
        peak_locked_next     = 1'b0;
        clear_pending_next   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_active    <= 1'b0;
      need_rearm      <= 1'b0;
      peak_value      <= '0;
      previous_sample <= '0;
      decline_count   <= '0;
      peak_locked     <= 1'b0;
      clear_pending   <= 1'b0;
    end else if (step) begin
      alarm_active    <= alarm_active_next;
      need_rearm      <= need_rearm_next;
      peak_value      <= peak_value_next;
      previous_sample <= previous_sample_next;
      decline_count   <= decline_count_next;
      peak_locked     <= peak_locked_next;
      clear_pending   <= clear_pending_next;
    end
  end

  // clear start time only read while clear_pending is set
  always_ff @(posedge clk) begin
    if (step && clear_start_load) begin
      clear_start_ms <= s1_now;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      alarm               <= alarm_active_next;
      alarm_raised        <= raised;
      alarm_cleared       <= cleared;
      rearm_pending       <= need_rearm_next;
      flame_confirmed_out <= flame_conf_next;
      peak_level          <= peak_value_next;
    end
  end

  // Checks
  `GFAQ_ASSERT_NOW(a_raise_clear_excl, out_valid, !(alarm_raised && alarm_cleared), "raise and clear in one result")
  `GFAQ_ASSERT_NOW(a_raise_sets_alarm, out_valid && alarm_raised, alarm && !rearm_pending, "raise without active alarm")
  `GFAQ_ASSERT_NOW(a_clear_zeroes_peak, out_valid && alarm_cleared, !alarm && peak_level == '0, "clear left alarm or peak")
  `GFAQ_ASSERT_NEXT(a_stage1_holds, s1_valid && !advance, s1_valid && $stable(s1_gas), "stalled request lost")

endmodule

@@ verif/tb.sv @@
module tb;
  import gfaq_pkg::*;

  localparam int SAMPLE_W = 10;
  localparam int TIME_W = 32;
  localparam int REG_SLOTS = 2 ** CFG_INDEX_BITS;
  // Indexes past the register map; writes there must be ignored
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 3'd7;
  localparam int PIPE_SLACK = 4;          // two-stage pipe plus margin
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int TIMEOUT = 4_000_000;

  typedef struct packed {
    logic                alarm;
    logic                raised;
    logic                cleared;
    logic                rearm;
    logic                flame;
    logic [SAMPLE_W-1:0] peak;
  } verdict_t;

  // Alarm qualifier predictor plus the queue of verdicts still due from the block
  class alarm_checker;
    logic [SAMPLE_W-1:0] gas_thr = SAMPLE_W'(TRIP_LEVEL_RST);
    logic [SAMPLE_W-1:0] rearm_thr = SAMPLE_W'(REARM_THRESHOLD_RST);
    logic [SAMPLE_W-1:0] drop = SAMPLE_W'(DROP_MARGIN_RST);
    logic [SAMPLE_W-1:0] decl_need = SAMPLE_W'(LOCK_DECLINES_RST);
    logic [HOLD_BITS-1:0] clear_hold = HOLD_BITS'(CLEAR_HOLD_RST);
    logic [HOLD_BITS-1:0] flame_hold = HOLD_BITS'(FLAME_HOLD_RST);

    logic active = 1'b0, rearm = 1'b0, locked = 1'b0, clr_pend = 1'b0;
    logic fl_pend = 1'b0, fl_conf = 1'b0;
    logic [SAMPLE_W-1:0] peak = '0, prev = '0;
    logic [DECLINE_BITS-1:0] declines = '0;
    logic [TIME_W-1:0] clr_t0 = '0, fl_t0 = '0;

    verdict_t expected_verdicts[$];
    int errors = 0, checked = 0, raises = 0, clears = 0, rearms = 0;

    function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_TRIP_LEVEL:      gas_thr = data[SAMPLE_W-1:0];
        CFG_REARM_THRESHOLD: rearm_thr = data[SAMPLE_W-1:0];
        CFG_DROP_MARGIN:     drop = data[SAMPLE_W-1:0];
        CFG_LOCK_DECLINES:   decl_need = data[SAMPLE_W-1:0];
        CFG_CLEAR_HOLD:      clear_hold = data[HOLD_BITS-1:0];
        CFG_FLAME_HOLD:      flame_hold = data[HOLD_BITS-1:0];
        default: ;
      endcase
    endfunction

    // Advance the model by one accepted request and queue the verdict it causes
    function void take_sample(logic [TIME_W-1:0] t, logic [SAMPLE_W-1:0] gas, logic flame);
      logic raised, cleared, cond;
      logic [SAMPLE_W:0] gas_plus_drop;
      verdict_t v;
      raised = 1'b0;
      cleared = 1'b0;

      // flame must persist for the hold time
      if (flame) begin
        if (!fl_pend) begin
          fl_pend = 1'b1;
          fl_t0 = t;
        end else if (!fl_conf && (t - fl_t0) >= flame_hold) begin
          fl_conf = 1'b1;
        end
      end else begin
        fl_pend = 1'b0;
        fl_conf = 1'b0;
      end

      if (rearm && gas < rearm_thr)
        rearm = 1'b0;

      if (!active) begin
        // trigger only seeds the tracker
        if (!rearm && (gas > gas_thr || fl_conf)) begin
          active = 1'b1;
          raised = 1'b1;
          peak = gas;
          prev = gas;
          declines = '0;
          locked = 1'b0;
          clr_pend = 1'b0;
        end
      end else begin
        // peak tracking and decline counting
        if (gas > peak) begin
          peak = gas;
          declines = '0;
          locked = 1'b0;
          clr_pend = 1'b0;
        end else if (gas < prev) begin
          if (declines < DECLINE_MAX)
            declines++;
          if (declines >= decl_need)
            locked = 1'b1;
        end else if (!locked) begin
          declines = '0;
        end
        prev = gas;

        // clear condition, with the drop sum kept one bit wider
        gas_plus_drop = gas + drop;
        cond = !flame && ((locked && gas_plus_drop <= {1'b0, peak}) || gas < gas_thr);
        if (cond) begin
          if (!clr_pend) begin
            clr_pend = 1'b1;
            clr_t0 = t;
          end else if ((t - clr_t0) >= clear_hold) begin
            cleared = 1'b1;
          end
        end else begin
          clr_pend = 1'b0;
        end

        if (cleared) begin
          if (gas >= gas_thr)
            rearm = 1'b1;
          active = 1'b0;
          peak = '0;
          prev = '0;
          declines = '0;
          locked = 1'b0;
          clr_pend = 1'b0;
        end
      end

      v = {active, raised, cleared, rearm, fl_conf, peak};
      expected_verdicts.push_back(v);
    endfunction

    function void compare_field(string label, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      end
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        errors++;
        $display("%0t: result with no request outstanding, actual %h", $time, got);
        return;
      end
      want = expected_verdicts.pop_front();
      compare_field("alarm", want.alarm, got.alarm);
      compare_field("alarm_raised", want.raised, got.raised);
      compare_field("alarm_cleared", want.cleared, got.cleared);
      compare_field("rearm_pending", want.rearm, got.rearm);
      compare_field("flame_confirmed_out", want.flame, got.flame);
      compare_field("peak_level", want.peak, got.peak);
      checked++;
      raises += want.raised;
      clears += want.cleared;
      rearms += want.rearm;
    endfunction

    function int outstanding();
      return expected_verdicts.size();
    endfunction

    function void report_leftovers();
      if (expected_verdicts.size() != 0) begin
        errors += expected_verdicts.size();
        $display("%0t: %0d expected results never arrived", $time, expected_verdicts.size());
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [TIME_W-1:0] now_ms = '0;
  logic [SAMPLE_W-1:0] gas_level = '0;
  logic flame_seen = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic alarm, alarm_raised, alarm_cleared, rearm_pending, flame_confirmed_out;
  logic [SAMPLE_W-1:0] peak_level;
  verdict_t dut_verdict;

  alarm_checker sb;

  // stimulus knobs
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int long_hold_requests = 0;
  int long_holds_done = 0;
  int hold_left = 0;
  int requests_sent = 0;
  int settings_run = 1;

  // sensor walk state
  int walk_gas = 0;
  bit rising = 1'b1;
  bit flame_on = 1'b0;
  logic [TIME_W-1:0] walk_ms = 32'd1000;

  always #5 clk = ~clk;

  gas_flame_alarm_qualifier #(
    .SAMPLE_BITS(SAMPLE_W),
    .TIME_BITS(TIME_W)
  ) dut (
    .clk, .rst,
    .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .now_ms, .gas_level, .flame_seen,
    .out_valid, .out_stall, .alarm, .alarm_raised, .alarm_cleared,
    .rearm_pending, .flame_confirmed_out, .peak_level
  );

  assign dut_verdict = {alarm, alarm_raised, alarm_cleared, rearm_pending,
                        flame_confirmed_out, peak_level};

  // Result side: check every accepted result, then pick the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_verdict(dut_verdict);
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (long_holds_done < long_hold_requests) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD_CYCLES - 1;
      long_holds_done <= long_holds_done + 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // Offer one request, with an optional idle gap first; returns once accepted
  task automatic send_request(input logic [TIME_W-1:0] t, input logic [SAMPLE_W-1:0] gas,
                              input logic flame);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < tx_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    now_ms <= t;
    gas_level <= gas;
    flame_seen <= flame;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_sample(t, gas, flame);
    requests_sent++;
  endtask

  // Stop sending and wait until every expected result is back
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  // Write all register slots; 10-bit registers get junk in the upper bits
  task automatic load_config(input logic [SAMPLE_W-1:0] thr, rearm_lvl, drop, decl,
                             input logic [HOLD_BITS-1:0] clr, flm);
    logic [CFG_DATA_BITS-1:0] vals [REG_SLOTS];
    vals[CFG_TRIP_LEVEL] = {6'($urandom), thr};
    vals[CFG_REARM_THRESHOLD] = {6'($urandom), rearm_lvl};
    vals[CFG_DROP_MARGIN] = {6'($urandom), drop};
    vals[CFG_LOCK_DECLINES] = {6'($urandom), decl};
    vals[CFG_CLEAR_HOLD] = clr;
    vals[CFG_FLAME_HOLD] = flm;
    vals[CFG_SPARE_LO] = 16'($urandom);
    vals[CFG_SPARE_HI] = 16'($urandom);
    for (int k = 0; k < REG_SLOTS; k++) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_INDEX_BITS'(k);
      cfg_data <= vals[k];
      @(posedge clk);
      sb.set_reg(CFG_INDEX_BITS'(k), vals[k]);
    end
    cfg_write <= 1'b0;
    settings_run++;
  endtask

  // Gas rises and falls in runs, flame comes in bursts; a few requests are noise
  task automatic send_walk_item(input int step_max);
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      walk_ms = $urandom;
      walk_gas = $urandom_range(0, 1023);
      flame_on = $urandom_range(0, 1);
    end else begin
      if ($urandom_range(0, 15) == 0)
        rising = !rising;
      if (rising)
        walk_gas += $urandom_range(0, 70);
      else
        walk_gas -= $urandom_range(0, 50);
      if (walk_gas > 1023) begin
        walk_gas = 1023;
        rising = 1'b0;
      end
      if (walk_gas < 0) begin
        walk_gas = 0;
        rising = 1'b1;
      end
      if ($urandom_range(0, 9) == 0)
        flame_on = !flame_on;
      walk_ms += $urandom_range(0, step_max);
    end
    send_request(walk_ms, walk_gas[SAMPLE_W-1:0], flame_on);
  endtask

  task automatic run_phase(input logic [SAMPLE_W-1:0] thr, rearm_lvl, drop, decl,
                           input logic [HOLD_BITS-1:0] clr, flm,
                           input int tx_pct, rx_pct, count, hold_at);
    int step_max;
    settle();
    load_config(thr, rearm_lvl, drop, decl, clr, flm);
    tx_idle_pct = tx_pct;
    rx_stall_pct <= rx_pct;
    // time steps scaled so the hold timers expire after a few samples
    step_max = ((clr > flm) ? int'(clr) : int'(flm)) / 3 + 3;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at)
        long_hold_requests <= long_hold_requests + 1;
      send_walk_item(step_max);
    end
  endtask

  // Over a thousand strict declines: the counter saturates and the peak never locks
  task automatic run_decline_ramp();
    settle();
    load_config(10'd0, 10'd1023, 10'd0, 10'd1001, 16'd0, 16'd0);
    tx_idle_pct = 10;
    rx_stall_pct <= 10;
    send_request(walk_ms, 10'd0, 1'b0);
    for (int level = 1002; level >= 0; level--) begin
      walk_ms += 7;
      send_request(walk_ms, SAMPLE_W'(level), 1'b0);
    end
  endtask

  initial begin
    int tx_pct, rx_pct;
    logic [SAMPLE_W-1:0] thr;
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests at the reset settings
    send_request(32'd0, 10'd0, 1'b0);
    send_request(32'd100, 10'd1023, 1'b0);     // raise on gas
    send_request(32'd200, 10'd1000, 1'b0);
    send_request(32'd300, 10'd1000, 1'b0);     // equal sample, count zeroed
    send_request(32'd400, 10'd900, 1'b0);
    send_request(32'd500, 10'd800, 1'b0);      // peak locks
    send_request(32'd600, 10'd850, 1'b0);      // rise below a locked peak
    send_request(32'd2500, 10'd860, 1'b0);     // clear while gas high, rearm set
    send_request(32'd2600, 10'd800, 1'b0);
    send_request(32'd2700, 10'd399, 1'b0);     // rearm released
    send_request(32'd2800, 10'd451, 1'b0);     // just above threshold
    send_request(32'd2900, 10'd450, 1'b1);
    send_request(32'd3000, 10'd449, 1'b0);
    send_request(32'd3100, 10'd449, 1'b1);     // flame blocks the clear
    send_request(32'd3200, 10'd449, 1'b0);
    send_request(32'd5200, 10'd449, 1'b0);     // clear with gas low
    send_request(32'd5300, 10'd10, 1'b1);
    send_request(32'd5799, 10'd10, 1'b1);      // one ms short of confirm
    send_request(32'd5800, 10'd10, 1'b1);      // raise on flame
    send_request(32'd5900, 10'd300, 1'b0);
    send_request(32'hFFFF_FC00, 10'd1023, 1'b0);
    send_request(32'hFFFF_FF00, 10'd0, 1'b0);
    send_request(32'h0000_0700, 10'd0, 1'b0);  // hold measured across the wrap
    send_request(32'hFFFF_FFFF, 10'd1023, 1'b1);
    send_request(32'h0000_0000, 10'd1023, 1'b1);

    // Fixed settings: defaults, all zero, all full scale, and a mixed set
    run_phase(10'd450, 10'd400, 10'd50, 10'd2, 16'd2000, 16'd500, 0, 0, 30, -1);
    run_phase(10'd0, 10'd0, 10'd0, 10'd0, 16'd0, 16'd0, 68, 0, 30, -1);
    run_phase(10'd1023, 10'd1023, 10'd1023, 10'd1023, 16'hFFFF, 16'hFFFF, 0, 68, 30, -1);
    run_phase(10'd300, 10'd200, 10'd100, 10'd1000, 16'd50, 16'd30, 10, 10, 30, -1);
    // long result hold-off while requests keep coming
    run_phase(10'd600, 10'd500, 10'd0, 10'd1, 16'd0, 16'd0, 0, 0, 30, 10);
    run_decline_ramp();

    // Random settings, rotating through the idle patterns
    for (int k = 0; k < 4; k++) begin
      tx_pct = (k % 4 == 1) ? 68 : (k % 4 == 3) ? 10 : 0;
      rx_pct = (k % 4 == 2) ? 68 : (k % 4 == 3) ? 10 : 0;
      thr = SAMPLE_W'($urandom_range(150, 850));
      run_phase(thr, SAMPLE_W'($urandom_range(0, thr)), SAMPLE_W'($urandom_range(0, 300)),
                SAMPLE_W'($urandom_range(0, 6)), HOLD_BITS'($urandom_range(0, 3000)),
                HOLD_BITS'($urandom_range(0, 1500)), tx_pct, rx_pct, 40, -1);
    end

    settle();
    repeat (PIPE_SLACK) @(posedge clk);
    sb.report_leftovers();
    $display("Run covered %0d requests over %0d register settings, including zero and",
             requests_sent, settings_run);
    $display("full-scale limits, a saturating decline run and a long output hold-off: "
             , "%0d results checked, %0d raises, %0d clears, %0d with rearm pending.",
             sb.checked, sb.raises, sb.clears, sb.rearms);
    if (sb.errors == 0) begin
      $display("gas_flame_alarm_qualifier verification clean");
    end else begin
      $display("gas_flame_alarm_qualifier verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #TIMEOUT;
    $display("%0t: timeout with %0d results outstanding", $time, sb.outstanding());
    $display("gas_flame_alarm_qualifier verification failed");
    $finish;
  end

endmodule
